// ===== sv/cbf_safety_projection_defines.svh =====
// ---------------------------------------------------------------------------
// cbf_safety_projection_defines.svh
// Assertion macros shared by the safety filter RTL.
// ---------------------------------------------------------------------------
`ifndef CBF_SAFETY_PROJECTION_DEFINES_SVH
`define CBF_SAFETY_PROJECTION_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define CBF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbf safety filter check failed");

// next-cycle implication
`define CBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbf safety filter check failed");

`endif

// ===== sv/cbf_pkg.sv =====
// ---------------------------------------------------------------------------
// cbf_pkg
// Widths, register indexes and beat types of the barrier safety filter.
// ---------------------------------------------------------------------------
package cbf_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int CFG_IDX_W     = 2;

    // products of two values are exact in 2W bits
    localparam int PROD_W = 2 * VALUE_WIDTH;
    // b = -dh*f0 - alpha*(h+slack) needs two more bits
    localparam int B_W    = PROD_W + 2;
    // magnitude of b shifted up by the fraction bits
    localparam int NUM_W  = B_W + FRACTION_BITS;
    // quotient bits kept; anything larger saturates
    localparam int Q_W    = VALUE_WIDTH + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BARRIER_SLACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX     = 2'd3;

    localparam logic [VALUE_WIDTH-2:0] RST_ALPHA = (VALUE_WIDTH-1)'(1 << FRACTION_BITS);
    localparam logic signed [VALUE_WIDTH-1:0] RST_DRIVE_MAX =
        VALUE_WIDTH'(1 << FRACTION_BITS);
    localparam logic signed [VALUE_WIDTH-1:0] RST_DRIVE_MIN = -RST_DRIVE_MAX;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] nominal_drive;
        logic signed [VALUE_WIDTH-1:0] barrier_value;
        logic signed [VALUE_WIDTH-1:0] barrier_gradient;
        logic signed [VALUE_WIDTH-1:0] drift_term;
        logic signed [VALUE_WIDTH-1:0] input_gain;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] safe_drive;
        logic                          barrier_active;
    } t_out_beat;

    // one divider stage
    typedef struct packed {
        logic                          vld;
        logic signed [VALUE_WIDTH-1:0] nom;
        logic                          apos;
        logic                          nneg;
        logic                          azero;
        logic                          ovf;
        logic [PROD_W-1:0]             den;
        logic [PROD_W-1:0]             rem;
        logic [Q_W-1:0]                nlo;
        logic [Q_W-1:0]                quo;
    } t_div_stage;

endpackage

// ===== sv/cbf_safety_projection.sv =====
// ---------------------------------------------------------------------------
// cbf_safety_projection
// Single-input barrier safety filter: bound b/A on the nominal drive, then
// box clamp. Fully pipelined, restoring divider one quotient bit per stage.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        in         i_in_valid / o_in_ready    i_in_data  (cbf_pkg::t_in_beat)
//  out       out        o_out_valid / i_out_ready  o_out_data (cbf_pkg::t_out_beat)
//  cfg       in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  One beat per cycle in and out while the output is not stalled. The stages are
//  three front stages (products, alpha term, b), a divider load stage,
//  VALUE_WIDTH+1 divider stages of one quotient bit each, a bound and an output stage.
//  Reset (synchronous, active low) clears the valid bits and loads register defaults.
//  A stall on the output freezes the whole pipe; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "cbf_safety_projection_defines.svh"

module cbf_safety_projection (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cbf_pkg::t_in_beat                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cbf_pkg::t_out_beat                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cbf_pkg::VALUE_WIDTH-1:0]   i_cfg_data
);
    import cbf_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W+1:0] HALF   = (W+2)'(1) << (W-1);
    localparam logic [W+1:0] HALF_M = HALF - (W+2)'(1);

    // configuration
    logic [W-2:0]         r_alpha;
    logic signed [W-1:0]  r_slack;
    logic signed [W-1:0]  r_dmin;
    logic signed [W-1:0]  r_dmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= RST_ALPHA;
            r_slack <= '0;
            r_dmin  <= RST_DRIVE_MIN;
            r_dmax  <= RST_DRIVE_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA_GAIN:    r_alpha <= i_cfg_data[W-2:0];
                CFG_BARRIER_SLACK: r_slack <= i_cfg_data;
                CFG_DRIVE_MIN:     r_dmin  <= i_cfg_data;
                CFG_DRIVE_MAX:     r_dmax  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // stage 1: A = dh*g, dh*f0, h+slack
    logic                     r1_vld;
    logic signed [W-1:0]      r1_nom;
    logic signed [PROD_W-1:0] r1_a;
    logic signed [PROD_W-1:0] r1_p1;
    logic signed [W:0]        r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_nom <= i_in_data.nominal_drive;
            r1_a   <= i_in_data.barrier_gradient * i_in_data.input_gain;
            r1_p1  <= i_in_data.barrier_gradient * i_in_data.drift_term;
            r1_s   <= {i_in_data.barrier_value[W-1], i_in_data.barrier_value}
                    + {r_slack[W-1], r_slack};
        end
    end

    // stage 2: alpha*(h+slack)
    logic                     r2_vld;
    logic signed [W-1:0]      r2_nom;
    logic signed [PROD_W-1:0] r2_a;
    logic signed [PROD_W-1:0] r2_p1;
    logic signed [PROD_W-1:0] r2_p2;
    logic signed [W+1:0]      n_alpha_s;
    logic signed [2*W+1:0]    n_p2;

    assign n_alpha_s = {1'b0, 1'b0, 1'b0, r_alpha};
    assign n_p2      = n_alpha_s * r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_nom <= r1_nom;
            r2_a   <= r1_a;
            r2_p1  <= r1_p1;
            r2_p2  <= n_p2[PROD_W-1:0];
        end
    end

    // stage 3: b, sign and magnitudes
    logic signed [B_W-1:0] n_b;
    logic [B_W-1:0]        n_bmag;
    logic [PROD_W-1:0]     n_amag;

    assign n_b    = -(B_W'(r2_p1) + B_W'(r2_p2));
    assign n_bmag = n_b[B_W-1] ? B_W'(-n_b) : B_W'(n_b);
    assign n_amag = r2_a[PROD_W-1] ? PROD_W'(-r2_a) : PROD_W'(r2_a);

    logic                 r3_vld;
    logic signed [W-1:0]  r3_nom;
    logic [NUM_W-1:0]     r3_nmag;
    logic [PROD_W-1:0]    r3_amag;
    logic                 r3_apos;
    logic                 r3_nneg;
    logic                 r3_azero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_nom   <= r2_nom;
            r3_nmag  <= NUM_W'(n_bmag) << FRACTION_BITS;
            r3_amag  <= n_amag;
            r3_apos  <= !r2_a[PROD_W-1];
            r3_nneg  <= n_b[B_W-1];
            r3_azero <= (r2_a == '0);
        end
    end

    // divider: stage 0 takes the high part as the starting remainder
    t_div_stage r_div [0:Q_W];
    logic [NUM_W-Q_W-1:0] n_top;
    logic                 n_ovf;

    assign n_top = r3_nmag[NUM_W-1:Q_W];
    assign n_ovf = ({{(PROD_W){1'b0}}, n_top} >= {{(NUM_W-Q_W){1'b0}}, r3_amag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div[0].vld <= 1'b0;
        end else if (en) begin
            r_div[0].vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0].nom   <= r3_nom;
            r_div[0].apos  <= r3_apos;
            r_div[0].nneg  <= r3_nneg;
            r_div[0].azero <= r3_azero;
            r_div[0].ovf   <= n_ovf;
            r_div[0].den   <= r3_amag;
            // remainder only meaningful when not overflowed (then top < den)
            r_div[0].rem   <= PROD_W'(n_top);
            r_div[0].nlo   <= r3_nmag[Q_W-1:0];
            r_div[0].quo   <= '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        t_div_stage        n_st;
        logic [PROD_W:0]   n_t;
        logic              n_ge;

        assign n_t  = {r_div[k].rem, r_div[k].nlo[Q_W-1-k]};
        assign n_ge = (n_t >= {1'b0, r_div[k].den});

        always_comb begin
            n_st      = r_div[k];
            n_st.rem  = n_ge ? PROD_W'(n_t - {1'b0, r_div[k].den}) : n_t[PROD_W-1:0];
            n_st.quo[Q_W-1-k] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[k+1].vld <= 1'b0;
            end else if (en) begin
                r_div[k+1].vld <= r_div[k].vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[k+1].nom   <= n_st.nom;
                r_div[k+1].apos  <= n_st.apos;
                r_div[k+1].nneg  <= n_st.nneg;
                r_div[k+1].azero <= n_st.azero;
                r_div[k+1].ovf   <= n_st.ovf;
                r_div[k+1].den   <= n_st.den;
                r_div[k+1].rem   <= n_st.rem;
                r_div[k+1].nlo   <= n_st.nlo;
                r_div[k+1].quo   <= n_st.quo;
            end
        end
    end

    // bound stage: round toward the safe side, saturate
    t_div_stage          dv;
    logic                n_up;
    logic                n_bneg;
    logic [W+1:0]        n_mag;
    logic signed [W-1:0] n_bound;

    assign dv     = r_div[Q_W];
    assign n_up   = !dv.nneg && (dv.rem != '0);
    // negative bound: A>0 with b<0, or A<0 with b>0
    assign n_bneg = dv.apos ? dv.nneg : (!dv.nneg && (dv.nlo != '0 || dv.quo != '0
                    || dv.rem != '0 || dv.ovf));
    assign n_mag  = (W+2)'(dv.quo) + (W+2)'(n_up);

    always_comb begin
        if (n_bneg) begin
            n_bound = (dv.ovf || n_mag > HALF) ? S_MIN : W'(-n_mag);
        end else begin
            n_bound = (dv.ovf || n_mag > HALF_M) ? S_MAX : W'(n_mag);
        end
    end

    logic                 rb_vld;
    logic signed [W-1:0]  rb_nom;
    logic signed [W-1:0]  rb_bound;
    logic                 rb_apos;
    logic                 rb_azero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_vld <= 1'b0;
        end else if (en) begin
            rb_vld <= dv.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_nom   <= dv.nom;
            rb_bound <= n_bound;
            rb_apos  <= dv.apos;
            rb_azero <= dv.azero;
        end
    end

    // output stage: replace and clamp
    logic                n_act;
    logic signed [W-1:0] n_u;
    logic signed [W-1:0] n_drive;

    assign n_act = !rb_azero && (rb_apos ? (rb_nom < rb_bound) : (rb_nom > rb_bound));
    assign n_u   = n_act ? rb_bound : rb_nom;

    always_comb begin
        if (n_u < r_dmin) begin
            n_drive = r_dmin;
        end else if (n_u > r_dmax) begin
            n_drive = r_dmax;
        end else begin
            n_drive = n_u;
        end
    end

    logic      r_ovalid;
    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= rb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.safe_drive     <= n_drive;
            r_out.barrier_active <= n_act;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `CBF_ASSERT_NOW(a_stall_blocks_input, o_out_valid && !i_out_ready, !o_in_ready)
    `CBF_ASSERT_NOW(a_box_respected, o_out_valid && (r_dmin <= r_dmax),
        (o_out_data.safe_drive >= r_dmin) && (o_out_data.safe_drive <= r_dmax))
    `CBF_ASSERT_NOW(a_zero_gain_inactive, rb_vld && rb_azero, !n_act)
    `CBF_ASSERT_NEXT(a_valid_moves_on, en && rb_vld, o_out_valid)

endmodule
